### rtl/core/rms_pkg.sv
`timescale 1ns / 1ps

package rms_pkg;

    // Width of the sample and median fields on the stream ports.
    localparam int DATA_W = 32;

    // Default sizes handed down from the top level.
    localparam int MAX_SAMPLES_DEF = 256;
    localparam int SAMPLE_BITS_DEF = 32;

    // Operation applied at once to every cell of a sorted chain.
    typedef logic [1:0] op_t;
    localparam op_t OP_HOLD   = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_POPINS = 2'd2;

    // Status a cell shows to its neighbors: occupied, greater than the key,
    // and occupied but not greater than the key.
    typedef struct packed {
        logic occ;
        logic gt;
        logic le;
    } flag_t;

endpackage

### rtl/core/rms_cell.sv
`timescale 1ns / 1ps

module rms_cell #(
    parameter int W     = rms_pkg::SAMPLE_BITS_DEF,
    parameter int CNT_W = 9,
    parameter int IDX   = 0
) (
    input  logic                 aclk,
    input  rms_pkg::op_t         op,
    input  logic signed [W-1:0]  key,
    input  logic [CNT_W-1:0]     count,
    input  logic signed [W-1:0]  prev_val,
    input  rms_pkg::flag_t       prev_flag,
    input  logic signed [W-1:0]  next_val,
    input  rms_pkg::flag_t       next_flag,
    output logic signed [W-1:0]  val,
    output rms_pkg::flag_t       flag
);

    logic signed [W-1:0] val_reg;
    logic signed [W-1:0] val_next;
    logic                occ;
    logic                gt;

    assign occ  = count > CNT_W'(IDX);
    assign gt   = occ && (val_reg > key);
    assign flag = '{occ: occ, gt: gt, le: occ && !gt};
    assign val  = val_reg;

    always_comb begin
        case (op)
            rms_pkg::OP_INSERT: begin
                // Larger entries move one place away from the head; the key
                // lands where the first larger entry (or the first free cell) was.
                if (prev_flag.gt) begin
                    val_next = prev_val;
                end else if (gt || (!occ && prev_flag.occ)) begin
                    val_next = key;
                end else begin
                    val_next = val_reg;
                end
            end
            rms_pkg::OP_POPINS: begin
                // The head leaves, entries not above the key move toward the
                // head, and the key fills the gap behind them.
                if (next_flag.le) begin
                    val_next = next_val;
                end else if (flag.le) begin
                    val_next = key;
                end else begin
                    val_next = val_reg;
                end
            end
            default: begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

### rtl/core/rms_chain.sv
`timescale 1ns / 1ps

module rms_chain #(
    parameter int W     = rms_pkg::SAMPLE_BITS_DEF,
    parameter int CNT_W = 9,
    parameter int DEPTH = 128
) (
    input  logic                 aclk,
    input  rms_pkg::op_t         op,
    input  logic signed [W-1:0]  key,
    input  logic [CNT_W-1:0]     count,
    output logic signed [W-1:0]  head
);

    logic signed [W-1:0] vals [DEPTH];
    rms_pkg::flag_t      flags [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic signed [W-1:0] pv;
            logic signed [W-1:0] nv;
            rms_pkg::flag_t      pf;
            rms_pkg::flag_t      nf;

            if (i == 0) begin : g_first
                assign pv = '0;
                assign pf = '{occ: 1'b1, gt: 1'b0, le: 1'b0};
            end else begin : g_mid
                assign pv = vals[i-1];
                assign pf = flags[i-1];
            end

            if (i == DEPTH - 1) begin : g_last
                assign nv = '0;
                assign nf = '0;
            end else begin : g_inner
                assign nv = vals[i+1];
                assign nf = flags[i+1];
            end

            rms_cell #(
                .W     (W),
                .CNT_W (CNT_W),
                .IDX   (i)
            ) u_cell (
                .aclk      (aclk),
                .op        (op),
                .key       (key),
                .count     (count),
                .prev_val  (pv),
                .prev_flag (pf),
                .next_val  (nv),
                .next_flag (nf),
                .val       (vals[i]),
                .flag      (flags[i])
            );
        end
    endgenerate

    assign head = vals[0];

endmodule

### rtl/core/running_median_stream.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata = sample, s_tlast = last_sample
// m_        out        m_tvalid/m_tready  m_tdata = median, m_tuser = dropped
//
// An item is taken in every cycle while results drain; each result is registered
// first by the chain update and then by the median register.
// The samples live in two rows of compare-and-shift cells: the lower half in
// descending order and the upper half in ascending order, so the median only
// ever needs the two chain heads.
// Reset clears the fill counts and the valid flags; cell contents are never
// read unfilled.
// When the result register is stalled, s_tready drops once a median is pending.

module running_median_stream #(
    parameter int MAX_SAMPLES = rms_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = rms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [rms_pkg::DATA_W-1:0] s_tdata,   // [31:0] sample
    input  logic                       s_tlast,   // last_sample
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rms_pkg::DATA_W-1:0] m_tdata,   // [31:0] median
    output logic                       m_tuser    // [0] dropped
);

    localparam int W       = SAMPLE_BITS;
    localparam int L_DEPTH = (MAX_SAMPLES + 1) / 2;
    localparam int U_DEPTH = MAX_SAMPLES / 2;
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam bit MAX_ODD = (MAX_SAMPLES % 2) == 1;

    // Fill counts of the lower and upper chains. The lower chain always holds
    // as many samples as the upper one, or one more.
    logic [CNT_W-1:0] nl_reg, nl_next;
    logic [CNT_W-1:0] nu_reg, nu_next;

    // Median stage: an item whose chain update is done waits here.
    logic pend_reg, pend_next;
    logic pend_odd_reg, pend_odd_next;
    logic pend_drop_reg, pend_drop_next;

    // Result register.
    logic                m_valid_reg, m_valid_next;
    logic signed [W-1:0] med_reg, med_next;
    logic                drop_reg, drop_next;

    logic                accept;
    logic                load;
    logic                full;
    logic                even;
    logic [CNT_W-1:0]    total;
    logic signed [W-1:0] s_val;
    logic signed [W-1:0] l_head, u_head;
    logic signed [W-1:0] l0, u0;
    logic signed [W-1:0] l_key, u_key;
    rms_pkg::op_t        l_op, u_op;
    logic signed [W:0]   mid_sum;
    logic signed [W:0]   mid_adj;

    assign s_val  = s_tdata[W-1:0];
    assign accept = s_tvalid && s_tready;
    assign load   = pend_reg && (!m_valid_reg || m_tready);
    assign s_tready = !pend_reg || load;

    // The lower chain stores inverted samples so that both rows keep their
    // smallest key at the head; inversion reverses two's complement order.
    assign l0 = ~l_head;
    assign u0 = u_head;

    assign total = nl_reg + nu_reg;
    assign full  = total == CNT_W'(MAX_SAMPLES);
    assign even  = nl_reg == nu_reg;

    always_comb begin
        l_op           = rms_pkg::OP_HOLD;
        u_op           = rms_pkg::OP_HOLD;
        l_key          = ~s_val;
        u_key          = s_val;
        nl_next        = nl_reg;
        nu_next        = nu_reg;
        pend_odd_next  = pend_odd_reg;
        pend_drop_next = pend_drop_reg;

        if (accept) begin
            pend_drop_next = full;
            pend_odd_next  = full ? MAX_ODD : even;
            if (!full) begin
                if (even) begin
                    // The lower half grows. A sample above the upper head goes
                    // up, and the upper head moves down in its place.
                    nl_next = nl_reg + CNT_W'(1);
                    if (nu_reg == '0 || s_val <= u0) begin
                        l_op = rms_pkg::OP_INSERT;
                    end else begin
                        u_op  = rms_pkg::OP_POPINS;
                        l_op  = rms_pkg::OP_INSERT;
                        l_key = ~u0;
                    end
                end else begin
                    // The upper half grows. A sample below the lower head goes
                    // down, and the lower head moves up in its place.
                    nu_next = nu_reg + CNT_W'(1);
                    if (s_val >= l0) begin
                        u_op = rms_pkg::OP_INSERT;
                    end else begin
                        l_op  = rms_pkg::OP_POPINS;
                        u_op  = rms_pkg::OP_INSERT;
                        u_key = l0;
                    end
                end
            end
            if (s_tlast) begin
                nl_next = '0;
                nu_next = '0;
            end
        end
    end

    rms_chain #(
        .W     (W),
        .CNT_W (CNT_W),
        .DEPTH (L_DEPTH)
    ) u_lower (
        .aclk  (aclk),
        .op    (l_op),
        .key   (l_key),
        .count (nl_reg),
        .head  (l_head)
    );

    rms_chain #(
        .W     (W),
        .CNT_W (CNT_W),
        .DEPTH (U_DEPTH)
    ) u_upper (
        .aclk  (aclk),
        .op    (u_op),
        .key   (u_key),
        .count (nu_reg),
        .head  (u_head)
    );

    // Even count: the exact sum of the two middle samples, halved toward zero
    // by adding one to a negative sum before the arithmetic shift. A dropped
    // sample leaves the chains as they were, so the heads repeat the median.
    assign mid_sum = {l0[W-1], l0} + {u0[W-1], u0};
    assign mid_adj = mid_sum + (W + 1)'(mid_sum[W]);

    always_comb begin
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        med_next     = med_reg;
        drop_next    = drop_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            med_next     = pend_odd_reg ? l0 : mid_adj[W:1];
            drop_next    = pend_drop_reg;
            pend_next    = 1'b0;
        end
        if (accept) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nl_reg      <= '0;
            nu_reg      <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            nl_reg      <= nl_next;
            nu_reg      <= nu_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_odd_reg  <= pend_odd_next;
        pend_drop_reg <= pend_drop_next;
        med_reg       <= med_next;
        drop_reg      <= drop_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = rms_pkg::DATA_W'(med_reg);
    assign m_tuser  = drop_reg;

endmodule

### rtl/core/rms_checker.sv
`timescale 1ns / 1ps

module rms_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [rms_pkg::DATA_W-1:0] m_tdata,
    input logic                       m_tuser
);

    // Items taken in but whose results have not yet been handed over.
    logic [2:0] open_reg, open_next;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign open_next = open_reg + 3'(s_acc) - 3'(m_acc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_next;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_open_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg <= 3'd2)
        else $error("more than two items in flight");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> open_reg != 3'd0)
        else $error("result without an item");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && open_reg == 3'd0 |-> ##2 m_tvalid)
        else $error("result late on an empty pipeline");

endmodule

bind running_median_stream rms_checker u_rms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
